/* sv/sfe_pkg.sv */
// Shared constants and types for the stereo feedback echo block.
`timescale 1ns / 1ps

package sfe_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_BITS  = 16;
  localparam int FRAC_BITS  = 14;
  localparam int CNT_W      = $clog2(GAIN_BITS);

  typedef logic signed [GAIN_BITS-1:0] gain_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_FRAMES  = 2'd0,
    CFG_ECHO_GAIN     = 2'd1,
    CFG_FEEDBACK_GAIN = 2'd2,
    CFG_MONO_MODE     = 2'd3
  } cfg_reg_t;

  localparam logic [CFG_DATA_W-1:0] DELAY_FRAMES_RST  = 16'd9600;
  localparam gain_t                 ECHO_GAIN_RST     = 16'sd3277;
  localparam gain_t                 FEEDBACK_GAIN_RST = 16'sd8192;

endpackage

/* sv/sfe_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module sfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32768
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/stereo_feedback_echo.sv */
// Stereo feedback echo: delay ring in RAM and a shared bit-serial multiplier.
`timescale 1ns / 1ps

// The block takes one stereo frame per input transaction and returns one
// frame per output transaction. For each channel the sample stored at the
// ring pointer is scaled by echo_gain (Q2.14, rounded half up) to form the
// echo; the output is the saturated sum of input and echo, and the slot is
// rewritten with the saturated sum of input and feedback_gain times echo.
// Both gain products run on one shared multiplier that retires one gain bit
// per clock, and each product ends with a rounding step. A stereo frame
// needs four products from acceptance until the block is ready again, and
// a mono frame two. The result sits in an output register, so a new frame
// can be accepted while the previous result still waits to be taken; a
// finished frame waits only if that register is still full. Any
// configuration write restarts the ring at slot zero and empties it. The
// store needs no clearing pass: since the pointer walks the ring in order
// from slot zero, every slot read before the first wrap is still empty and
// is read as zero, and every slot read after it has been written.
// Configuration must only be written while no frame is in progress.
module stereo_feedback_echo #(
  parameter int MAX_DELAY_FRAMES = 32768,
  parameter int SAMPLE_BITS      = 16
) (
  input  logic clk,
  input  logic rst_n,
  // Input frame: left_sample (lowest bits), right_sample.
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      in_tdata,
  // Configuration write port.
  input  logic                                    cfg_we,
  input  logic [sfe_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [sfe_pkg::CFG_DATA_W-1:0]          cfg_wdata,
  // Result frame: left_out (lowest bits), right_out.
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      out_tdata
);

  import sfe_pkg::*;

  localparam int DW = ((2*SAMPLE_BITS+7)/8)*8;
  localparam int SB = SAMPLE_BITS;
  localparam int AW = (MAX_DELAY_FRAMES > 1) ? $clog2(MAX_DELAY_FRAMES) : 1;
  localparam int LW = (AW + 1 > 17) ? AW + 1 : 17;
  localparam int MW = SB + 2;               // multiplicand: stored sample or echo
  localparam int FW = SB + 3;               // rounded feedback term
  localparam int PW = MW + 1 + GAIN_BITS;   // full product
  localparam int SW = SB + 4;               // sum before saturation

  localparam logic signed [SW-1:0] SAT_MAX = {{(SW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_MIN = {{(SW-SB+1){1'b1}}, {(SB-1){1'b0}}};
  localparam logic [PW-1:0]        RND_HALF = PW'(1) << (FRAC_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_RND,
    S_DONE
  } state_t;

  function automatic logic [SB-1:0] sat_sb(input logic signed [SW-1:0] v);
    if (v > SAT_MAX) begin
      return SAT_MAX[SB-1:0];
    end else if (v < SAT_MIN) begin
      return SAT_MIN[SB-1:0];
    end
    return v[SB-1:0];
  endfunction

  state_t               state_r;
  logic [CFG_DATA_W-1:0] delay_frames_r;
  gain_t                echo_gain_r;
  gain_t                feedback_gain_r;
  logic                 mono_r;
  logic [AW-1:0]        ptr_r;
  logic                 wrapped_r;

  logic [SB-1:0]        in_l_r, in_r_r;
  logic [SB-1:0]        word_r;
  logic                 chan_r;
  logic                 phase_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [MW-1:0]        a_r;
  logic [MW:0]          h_r;
  logic [GAIN_BITS-1:0] l_r;
  logic [MW-1:0]        echo_r;
  logic [SB-1:0]        res_l_r, res_r_r, st_l_r, st_r_r;
  logic [SB-1:0]        out_l_r, out_r_r;
  logic                 out_tvalid_r;

  // Ring length and pointer advance.
  logic [LW-1:0] df_ext, ring_len, ptr_inc;
  logic          ptr_wrap;

  assign df_ext   = LW'(delay_frames_r);
  assign ring_len = (df_ext == '0) ? LW'(1) :
                    (df_ext > LW'(MAX_DELAY_FRAMES)) ? LW'(MAX_DELAY_FRAMES) : df_ext;
  assign ptr_inc  = LW'(ptr_r) + LW'(1);
  assign ptr_wrap = (ptr_inc >= ring_len);

  // One step of the shift-add multiplier; the top gain bit carries negative weight.
  logic [MW+1:0] mul_addend, mul_sum;
  logic [MW:0]   h_nxt;
  logic [GAIN_BITS-1:0] l_nxt;

  always_comb begin
    mul_addend = '0;
    if (l_r[0]) begin
      if (cnt_r == CNT_W'(GAIN_BITS - 1)) begin
        mul_addend = -{{2{a_r[MW-1]}}, a_r};
      end else begin
        mul_addend = {{2{a_r[MW-1]}}, a_r};
      end
    end
    mul_sum = {h_r[MW], h_r} + mul_addend;
    h_nxt   = mul_sum[MW+1:1];
    l_nxt   = {mul_sum[0], l_r[GAIN_BITS-1:1]};
  end

  // Rounding of the finished product and the saturated sums.
  logic [PW-1:0] rnd_sum;
  logic [FW-1:0] rnd_val;
  logic [SB-1:0] cur_in, sum_out, sum_store;

  always_comb begin
    rnd_sum   = {h_r, l_r} + RND_HALF;
    rnd_val   = rnd_sum[FRAC_BITS +: FW];
    cur_in    = chan_r ? in_r_r : in_l_r;
    sum_out   = sat_sb(signed'({{(SW-SB){cur_in[SB-1]}}, cur_in})
                       + signed'({{(SW-MW){echo_r[MW-1]}}, echo_r}));
    sum_store = sat_sb(signed'({{(SW-SB){cur_in[SB-1]}}, cur_in})
                       + signed'({{(SW-FW){rnd_val[FW-1]}}, rnd_val}));
  end

  // Delay store: left half in the low bits, right half in the high bits.
  logic [2*SB-1:0] rd_data, ld_word;
  logic            out_free, ram_we;

  assign out_free = !out_tvalid_r || out_tready;
  assign ram_we   = (state_r == S_DONE) && out_free;
  assign ld_word  = wrapped_r ? rd_data : '0;

  sfe_ram #(
    .WIDTH(2*SB),
    .DEPTH(MAX_DELAY_FRAMES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ptr_r),
    .wdata({st_r_r, st_l_r}),
    .raddr(ptr_r),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      delay_frames_r  <= DELAY_FRAMES_RST;
      echo_gain_r     <= ECHO_GAIN_RST;
      feedback_gain_r <= FEEDBACK_GAIN_RST;
      mono_r          <= 1'b0;
      ptr_r           <= '0;
      wrapped_r       <= 1'b0;
      out_tvalid_r    <= 1'b0;
    end else begin
      // A finished frame loads the output register as soon as it is free.
      if ((state_r == S_DONE) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            in_l_r  <= in_tdata[SB-1:0];
            in_r_r  <= in_tdata[2*SB-1:SB];
            state_r <= S_LOAD;
          end
        end

        S_LOAD: begin
          word_r  <= ld_word[2*SB-1:SB];
          st_r_r  <= ld_word[2*SB-1:SB];
          a_r     <= {{2{ld_word[SB-1]}}, ld_word[SB-1:0]};
          h_r     <= '0;
          l_r     <= echo_gain_r;
          cnt_r   <= '0;
          chan_r  <= 1'b0;
          phase_r <= 1'b0;
          state_r <= S_MUL;
        end

        S_MUL: begin
          h_r   <= h_nxt;
          l_r   <= l_nxt;
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(GAIN_BITS - 1)) begin
            state_r <= S_RND;
          end
        end

        S_RND: begin
          h_r   <= '0;
          cnt_r <= '0;
          if (!phase_r) begin
            // Echo is ready; next product is feedback gain times echo.
            echo_r  <= rnd_val[MW-1:0];
            a_r     <= rnd_val[MW-1:0];
            l_r     <= feedback_gain_r;
            phase_r <= 1'b1;
            state_r <= S_MUL;
          end else if (!chan_r) begin
            res_l_r <= sum_out;
            st_l_r  <= sum_store;
            if (mono_r) begin
              res_r_r <= sum_out;
              state_r <= S_DONE;
            end else begin
              a_r     <= {{2{word_r[SB-1]}}, word_r};
              l_r     <= echo_gain_r;
              chan_r  <= 1'b1;
              phase_r <= 1'b0;
              state_r <= S_MUL;
            end
          end else begin
            res_r_r <= sum_out;
            st_r_r  <= sum_store;
            state_r <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_l_r      <= res_l_r;
            out_r_r      <= res_r_r;
            if (ptr_wrap) begin
              ptr_r     <= '0;
              wrapped_r <= 1'b1;
            end else begin
              ptr_r <= ptr_inc[AW-1:0];
            end
            state_r <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_DELAY_FRAMES:  delay_frames_r  <= cfg_wdata;
          CFG_ECHO_GAIN:     echo_gain_r     <= cfg_wdata;
          CFG_FEEDBACK_GAIN: feedback_gain_r <= cfg_wdata;
          CFG_MONO_MODE:     mono_r          <= cfg_wdata[0];
          default: begin
          end
        endcase
        ptr_r     <= '0;
        wrapped_r <= 1'b0;
      end
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = DW'({out_r_r, out_l_r});

endmodule

/* sv/sfe_checker.sv */
// Port-level checks for the stereo feedback echo block, bound to the top level.
`timescale 1ns / 1ps

module sfe_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                                    clk,
  input logic                                    rst_n,
  input logic                                    in_tvalid,
  input logic                                    in_tready,
  input logic                                    cfg_we,
  input logic [sfe_pkg::CFG_IDX_W-1:0]           cfg_index,
  input logic [sfe_pkg::CFG_DATA_W-1:0]          cfg_wdata,
  input logic                                    out_tvalid,
  input logic                                    out_tready,
  input logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      out_tdata
);

  import sfe_pkg::*;

  localparam int SB = SAMPLE_BITS;

  // Mono setting as seen from the configuration port.
  logic mono_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mono_seen_r <= 1'b0;
    end else if (cfg_we && (cfg_index == CFG_MONO_MODE)) begin
      mono_seen_r <= cfg_wdata[0];
    end
  end

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped before it was taken");

  a_out_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second frame accepted while one is in progress");

  a_mono_duplicates: assert property (@(posedge clk) disable iff (!rst_n)
    mono_seen_r && out_tvalid |-> out_tdata[SB-1:0] == out_tdata[2*SB-1:SB])
    else $error("mono result differs between channels");

endmodule

bind stereo_feedback_echo sfe_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_sfe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_wdata (cfg_wdata),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

/* tb/tb_stereo_feedback_echo.sv */
// Self-checking testbench for the stereo feedback echo block.
`timescale 1ns / 1ps

// The testbench drives stereo frames into the echo block over the input
// stream and checks every output transaction against an expected frame:
// a typed-in one, or one from a predictor that keeps its own copy of the
// delay ring, the ring pointer and the four registers. Inputs change on the
// falling clock edge and the DUT outputs are sampled on the rising edge, so
// no check depends on the order of events in a step.
// The run has two parts. A short directed plan covers the full-scale
// samples, gains of one, minus two and nearly plus two, zero gains, mono
// mode, a delay length of zero (treated as one), a delay length beyond the
// store (treated as the store size) and the store clearing that follows
// every register write. Random phases follow, each with its own register
// settings and its own idle pattern on both stream sides.
module tb_stereo_feedback_echo;
  import sfe_pkg::*;

  localparam int SAMPLE_W     = 16;
  localparam int FRAME_W      = 2 * SAMPLE_W;
  localparam int RING_DEPTH   = 32768;
  localparam int RANDOM_ITEMS = 1150;
  // Limit on a run without any transaction; reaching it means the block has hung.
  localparam int IDLE_LIMIT   = 2000;
  // Cycles to keep listening after the last expected result has arrived.
  localparam int TAIL_CYCLES  = 150;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Packed so that a cast from tdata puts left in the low half.
  typedef struct packed {
    sample_t right;
    sample_t left;
  } frame_t;

  // Output sample and the value written back to the ring slot.
  typedef struct packed {
    sample_t out;
    sample_t keep;
  } chan_t;

  typedef enum logic {
    STEP_FRAME,
    STEP_WRITE
  } step_kind_t;

  typedef struct {
    step_kind_t kind;
    cfg_reg_t   reg_idx;
    logic [CFG_DATA_W-1:0] value;
    sample_t    left;
    sample_t    right;
    bit         typed;
    frame_t     want;
  } plan_step_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [FRAME_W-1:0]    in_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [FRAME_W-1:0]    out_tdata;

  // Predictor state: the ring halves, the pointer and the register copies.
  sample_t               ring_left  [0:RING_DEPTH-1];
  sample_t               ring_right [0:RING_DEPTH-1];
  int                    ring_ptr;
  logic [CFG_DATA_W-1:0] delay_q;
  gain_t                 echo_gain_q;
  gain_t                 feedback_gain_q;
  logic                  mono_q;

  frame_t     expected_frames[$];
  plan_step_t directed_plan[$];
  int         mismatches = 0;
  int         idle_cycles = 0;
  bit         source_calm = 1'b0;
  bit         sink_calm = 1'b0;

  stereo_feedback_echo dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: the run is stopped if neither stream moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_stereo_feedback_echo NOT OK");
        $finish;
      end
    end
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $realtime, msg);
    mismatches++;
  endtask

  // Round half up after dropping the 14 fraction bits of a Q2.14 gain.
  function automatic longint q14_round(input longint prod);
    return (prod + 64'sd8192) >>> FRAC_BITS;
  endfunction

  function automatic sample_t clamp_sample(input longint v);
    if (v > 64'sd32767) return 16'sh7fff;
    if (v < -64'sd32768) return 16'sh8000;
    return sample_t'(v);
  endfunction

  // One comb section: the echo keeps full precision, only the output and
  // the value written back are clamped to the sample range.
  function automatic chan_t comb_channel(input sample_t x, input sample_t slot);
    longint echo;
    longint fb;
    chan_t  res;
    echo = q14_round(longint'(slot) * longint'(echo_gain_q));
    fb = q14_round(longint'(feedback_gain_q) * echo);
    res.out = clamp_sample(longint'(x) + echo);
    res.keep = clamp_sample(longint'(x) + fb);
    return res;
  endfunction

  // Works out the output frame for one accepted input frame and advances
  // the predicted ring.
  function automatic frame_t predict_echo_frame(input sample_t l_in, input sample_t r_in);
    int     ring_len;
    int     p;
    chan_t  lc;
    chan_t  rc;
    frame_t res;
    // A length of zero behaves as one, and lengths beyond the store are
    // held to the store size.
    ring_len = (delay_q == 0) ? 1 : ((delay_q > RING_DEPTH) ? RING_DEPTH : int'(delay_q));
    p = (ring_ptr >= ring_len) ? 0 : ring_ptr;
    lc = comb_channel(l_in, ring_left[p]);
    ring_left[p] = lc.keep;
    res.left = lc.out;
    if (mono_q) begin
      // The right half of the ring is left alone in mono mode.
      res.right = lc.out;
    end else begin
      rc = comb_channel(r_in, ring_right[p]);
      ring_right[p] = rc.keep;
      res.right = rc.out;
    end
    p++;
    if (p >= ring_len) p = 0;
    ring_ptr = p;
    return res;
  endfunction

  function automatic void clear_ring();
    for (int i = 0; i < RING_DEPTH; i++) begin
      ring_left[i] = '0;
      ring_right[i] = '0;
    end
    ring_ptr = 0;
  endfunction

  // Register writes are issued only when every result has been taken, so
  // the block is idle. Any write restarts and empties the ring.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    in_tvalid = 1'b0;
    while (expected_frames.size() != 0) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_DELAY_FRAMES:  delay_q = val;
      CFG_ECHO_GAIN:     echo_gain_q = gain_t'(val);
      CFG_FEEDBACK_GAIN: feedback_gain_q = gain_t'(val);
      CFG_MONO_MODE:     mono_q = val[0];
      default:           ;
    endcase
    clear_ring();
  endtask

  // Offers one frame after a random gap and waits for the handshake. The
  // expectation is either the typed-in frame or the predicted one; the
  // predictor runs in both cases to keep its ring in step.
  task automatic push_frame(input sample_t l, input sample_t r, input bit typed,
                            input frame_t want);
    int     gap;
    frame_t pred;
    gap = source_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {r, l};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = predict_echo_frame(l, r);
    expected_frames.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  function automatic void plan_write(input cfg_reg_t idx, input int val);
    plan_step_t s;
    s.kind = STEP_WRITE;
    s.reg_idx = idx;
    s.value = val[CFG_DATA_W-1:0];
    s.left = '0;
    s.right = '0;
    s.typed = 1'b0;
    s.want = '0;
    directed_plan.push_back(s);
  endfunction

  function automatic void plan_frame(input int l, input int r, input bit typed,
                                     input int wl, input int wr);
    plan_step_t s;
    s.kind = STEP_FRAME;
    s.reg_idx = CFG_DELAY_FRAMES;
    s.value = '0;
    s.left = sample_t'(l);
    s.right = sample_t'(r);
    s.typed = typed;
    s.want.left = sample_t'(wl);
    s.want.right = sample_t'(wr);
    directed_plan.push_back(s);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      1: begin
        case ($urandom_range(0, 2))
          0:       return 16'h0000;
          1:       return 16'h4000;
          default: return 16'hc000;
        endcase
      end
      default: return CFG_DATA_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly short rings so that the echo and its feedback show up quickly.
  function automatic logic [CFG_DATA_W-1:0] pick_delay();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'd32768;
      2:       return CFG_DATA_W'($urandom_range(32769, 65535));
      3:       return CFG_DATA_W'($urandom_range(25, 40000));
      default: return CFG_DATA_W'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return sample_t'(int'($urandom_range(0, 511)) - 256);
      default: return sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // Result side: draws a stall for every result, then checks it against
  // the oldest expectation.
  initial begin : result_sink
    int     gap;
    frame_t got;
    frame_t want;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = sink_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got = frame_t'(out_tdata);
      if (expected_frames.size() == 0) begin
        flag_mismatch($sformatf("result (%0d, %0d) with nothing expected",
                                $signed(got.left), $signed(got.right)));
      end else begin
        want = expected_frames.pop_front();
        if (got.left !== want.left)
          flag_mismatch($sformatf("left_out got %0d expected %0d",
                                  $signed(got.left), $signed(want.left)));
        if (got.right !== want.right)
          flag_mismatch($sformatf("right_out got %0d expected %0d",
                                  $signed(got.right), $signed(want.right)));
      end
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int         frames_sent;
    int         phase_len;
    plan_step_t s;
    frame_t     none;
    none = '0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_DELAY_FRAMES;
    cfg_wdata = '0;
    delay_q = DELAY_FRAMES_RST;
    echo_gain_q = ECHO_GAIN_RST;
    feedback_gain_q = FEEDBACK_GAIN_RST;
    mono_q = 1'b0;
    clear_ring();

    // Directed plan. Typed expectations appear only where the ring is known
    // to be empty, so the output must equal the input (the left one in mono).
    // Reset settings: a 9600-frame ring, nothing read back yet.
    plan_frame(32767, -32768, 1'b1, 32767, -32768);
    plan_frame(-32768, 32767, 1'b1, -32768, 32767);
    plan_frame(0, 0, 1'b1, 0, 0);
    // Ring of one frame with unity gains: each frame hears the last one.
    plan_write(CFG_DELAY_FRAMES, 1);
    plan_write(CFG_ECHO_GAIN, 16384);
    plan_write(CFG_FEEDBACK_GAIN, 16384);
    plan_frame(1000, -1000, 1'b1, 1000, -1000);
    plan_frame(0, 0, 1'b0, 0, 0);
    plan_frame(32767, -32768, 1'b0, 0, 0);
    plan_frame(32767, -32768, 1'b0, 0, 0);
    // Echo gain of minus two: the unclamped echo overshoots the range.
    plan_write(CFG_ECHO_GAIN, -32768);
    plan_frame(32767, -32768, 1'b1, 32767, -32768);
    plan_frame(0, 0, 1'b0, 0, 0);
    plan_frame(-32768, 32767, 1'b0, 0, 0);
    // Feedback gain of minus two on top.
    plan_write(CFG_FEEDBACK_GAIN, -32768);
    plan_frame(20000, -20000, 1'b1, 20000, -20000);
    plan_frame(0, 0, 1'b0, 0, 0);
    plan_write(CFG_ECHO_GAIN, 32767);
    plan_frame(-32768, 32767, 1'b1, -32768, 32767);
    plan_frame(5, 5, 1'b0, 0, 0);
    // Mono mode: the left result appears on both outputs.
    plan_write(CFG_MONO_MODE, 1);
    plan_frame(12345, -777, 1'b1, 12345, 12345);
    plan_frame(-3, 9999, 1'b0, 0, 0);
    plan_frame(0, -32768, 1'b0, 0, 0);
    // A delay length of zero behaves as a one-frame ring.
    plan_write(CFG_DELAY_FRAMES, 0);
    plan_frame(7000, 1, 1'b1, 7000, 7000);
    plan_frame(0, 0, 1'b0, 0, 0);
    // Back to stereo, with a length beyond the store.
    plan_write(CFG_MONO_MODE, 0);
    plan_write(CFG_DELAY_FRAMES, 65535);
    plan_frame(-20000, 20000, 1'b1, -20000, 20000);
    plan_frame(1, 2, 1'b0, 0, 0);
    // Full store length with both gains at zero.
    plan_write(CFG_DELAY_FRAMES, 32768);
    plan_write(CFG_ECHO_GAIN, 0);
    plan_write(CFG_FEEDBACK_GAIN, 0);
    plan_frame(32767, 32767, 1'b1, 32767, 32767);
    // Two-frame ring: the first pass over both slots reads empty slots.
    plan_write(CFG_DELAY_FRAMES, 2);
    plan_write(CFG_ECHO_GAIN, 16384);
    plan_write(CFG_FEEDBACK_GAIN, 8192);
    plan_frame(100, 200, 1'b1, 100, 200);
    plan_frame(300, 400, 1'b1, 300, 400);
    plan_frame(0, 0, 1'b0, 0, 0);

    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_plan[i]) begin
      s = directed_plan[i];
      if (s.kind == STEP_WRITE) begin
        write_reg(s.reg_idx, s.value);
      end else begin
        push_frame(s.left, s.right, s.typed, s.want);
      end
    end

    // Random phases: new settings, a new idle pattern, then a burst of
    // frames. Each register is rewritten with a fair chance per phase.
    frames_sent = 0;
    while (frames_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) write_reg(CFG_DELAY_FRAMES, pick_delay());
      if ($urandom_range(0, 3) != 0) write_reg(CFG_ECHO_GAIN, pick_gain());
      if ($urandom_range(0, 3) != 0) write_reg(CFG_FEEDBACK_GAIN, pick_gain());
      if ($urandom_range(0, 3) != 0)
        write_reg(CFG_MONO_MODE, CFG_DATA_W'($urandom_range(0, 1)));
      source_calm = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 110);
      if (phase_len > RANDOM_ITEMS - frames_sent) phase_len = RANDOM_ITEMS - frames_sent;
      repeat (phase_len) begin
        push_frame(pick_sample(), pick_sample(), 1'b0, none);
        frames_sent++;
      end
    end

    in_tvalid = 1'b0;
    while (expected_frames.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_frames.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_frames.size()));
    if (mismatches == 0) begin
      $display("tb_stereo_feedback_echo OK");
    end else begin
      $display("tb_stereo_feedback_echo NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/sfe_pkg.sv
sv/sfe_ram.sv
sv/stereo_feedback_echo.sv
sv/sfe_checker.sv
tb/tb_stereo_feedback_echo.sv
